/* design/efp_pkg.sv */
// shared types for the escape-time fractal pixel engine
package efp_pkg;

	// register port address width (seven 32-bit registers)
	localparam int CFG_AW = 5;

	localparam logic [1:0] KIND_JULIA  = 2'd1;
	localparam logic [1:0] KIND_LAMBDA = 2'd2;

	typedef enum logic [2:0] {
		REG_KIND,
		REG_X_START,
		REG_Y_START,
		REG_X_STEP,
		REG_Y_STEP,
		REG_C_RE,
		REG_C_IM
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] x_start;
		logic signed [31:0] y_start;
		logic [30:0]        x_step;
		logic [30:0]        y_step;
		logic signed [31:0] c_re;
		logic signed [31:0] c_im;
	} cfg_t;

	// multiplier operand sources
	typedef enum logic [3:0] {
		OPND_COL,
		OPND_ROW,
		OPND_XSTEP,
		OPND_YSTEP,
		OPND_X,
		OPND_Y,
		OPND_XX,
		OPND_YY,
		OPND_XY,
		OPND_CRE,
		OPND_CIM
	} opnd_t;

	// where a finished product goes
	typedef enum logic [2:0] {
		DST_NONE,
		DST_X0,
		DST_Y0,
		DST_XX,
		DST_YY,
		DST_XY,
		DST_ACCX,
		DST_ACCY
	} dst_t;

	// accumulate operation on a scaled product
	typedef enum logic [2:0] {
		AOP_LD,
		AOP_ADD,
		AOP_SUB,
		AOP_ADD2,
		AOP_SUB2
	} aop_t;

	typedef struct packed {
		logic  ld;
		opnd_t opa;
		opnd_t opb;
		dst_t  dst;
		aop_t  aop;
		logic  upd_quad;
		logic  upd_lam;
	} ctl_t;

	typedef struct packed {
		logic esc;
	} sts_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAP,
		S_SQ,
		S_CALC,
		S_LAM,
		S_HOLD
	} state_t;

endpackage

/* design/escape_time_fractal_pixel_top.sv */
// escape-time fractal pixel engine, one shared 33x33 multiplier under a step sequencer
// steps run per word: 1 .. MAX_ITER+1, with 3 products per step plus 10 more for lambda
// throughput: one word at a time, the next is accepted once the result sits in the output register
// reset: registers return to their defaults, sequencer idles, no result pending
module escape_time_fractal_pixel_top #(
	parameter int MAX_ITER = 155
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [efp_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [9:0]                 col,
	input  logic [9:0]                 row,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [23:0]                pixel_color,
	output logic [7:0]                 step_count,
	output logic                       escaped
);

	efp_pkg::cfg_t cfg;
	efp_pkg::ctl_t ctl;
	efp_pkg::sts_t sts;

	efp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	efp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.col    (col),
		.row    (row),
		.ctl    (ctl),
		.sts    (sts)
	);

	efp_seq #(
		.MAX_ITER (MAX_ITER)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (cfg.kind),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_color (pixel_color),
		.step_count  (step_count),
		.escaped     (escaped),
		.ctl         (ctl),
		.sts         (sts)
	);

endmodule

/* design/efp_regs.sv */
// configuration register file behind the apb-style port
module efp_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [efp_pkg::CFG_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output efp_pkg::cfg_t               cfg
);

	localparam logic signed [31:0] RST_X_START = -32'sd41943040;
	localparam logic signed [31:0] RST_Y_START = 32'sd25165824;
	localparam logic [30:0]        RST_X_STEP  = 31'd65536;
	localparam logic [30:0]        RST_Y_STEP  = 31'd49152;
	localparam logic signed [31:0] RST_C_RE    = 32'sd5033165;
	localparam logic signed [31:0] RST_C_IM    = 32'sd10066330;

	efp_pkg::cfg_t     cfg_q;
	efp_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = efp_pkg::reg_idx_t'(paddr[efp_pkg::CFG_AW-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind    <= 2'd0;
			cfg_q.x_start <= RST_X_START;
			cfg_q.y_start <= RST_Y_START;
			cfg_q.x_step  <= RST_X_STEP;
			cfg_q.y_step  <= RST_Y_STEP;
			cfg_q.c_re    <= RST_C_RE;
			cfg_q.c_im    <= RST_C_IM;
		end else if (wr_en) begin
			unique case (idx)
				efp_pkg::REG_KIND:    cfg_q.kind    <= pwdata[1:0];
				efp_pkg::REG_X_START: cfg_q.x_start <= pwdata;
				efp_pkg::REG_Y_START: cfg_q.y_start <= pwdata;
				efp_pkg::REG_X_STEP:  cfg_q.x_step  <= pwdata[30:0];
				efp_pkg::REG_Y_STEP:  cfg_q.y_step  <= pwdata[30:0];
				efp_pkg::REG_C_RE:    cfg_q.c_re    <= pwdata;
				efp_pkg::REG_C_IM:    cfg_q.c_im    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			efp_pkg::REG_KIND:    prdata = {30'd0, cfg_q.kind};
			efp_pkg::REG_X_START: prdata = cfg_q.x_start;
			efp_pkg::REG_Y_START: prdata = cfg_q.y_start;
			efp_pkg::REG_X_STEP:  prdata = {1'b0, cfg_q.x_step};
			efp_pkg::REG_Y_STEP:  prdata = {1'b0, cfg_q.y_step};
			efp_pkg::REG_C_RE:    prdata = cfg_q.c_re;
			efp_pkg::REG_C_IM:    prdata = cfg_q.c_im;
			default:              prdata = 32'd0;
		endcase
	end

endmodule

/* design/efp_dp.sv */
// shared multiplier, saturating accumulators and iterate registers
module efp_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  efp_pkg::cfg_t cfg,
	input  logic [9:0]    col,
	input  logic [9:0]    row,
	input  efp_pkg::ctl_t ctl,
	output efp_pkg::sts_t sts
);

	localparam int          Q_FRAC     = 24;
	localparam logic [63:0] LIM_QUAD   = 64'd1 << 50;
	localparam logic [63:0] LIM_LAMBDA = 64'd1 << 52;

	logic [9:0]         col_q, row_q;
	logic signed [31:0] x_q, y_q, x0_q, y0_q;
	logic signed [31:0] xx_q, yy_q, xy_q;
	logic signed [31:0] accx_q, accy_q;
	logic [63:0]        sqx_q;
	logic               esc_q;

	logic signed [63:0] p_s1;
	efp_pkg::dst_t      dst_s1;
	efp_pkg::aop_t      aop_s1;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic signed [31:0] term, term_sel, acc_base, acc_res;
	logic signed [31:0] cr, ci, quad_x, quad_y;
	logic [63:0]        mag, limit;

	function automatic logic signed [63:0] sx(input logic signed [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [32:0] opnd(input efp_pkg::opnd_t sel);
		case (sel)
			efp_pkg::OPND_COL:   return {23'd0, col_q};
			efp_pkg::OPND_ROW:   return {23'd0, row_q};
			efp_pkg::OPND_XSTEP: return {2'b00, cfg.x_step};
			efp_pkg::OPND_YSTEP: return {2'b00, cfg.y_step};
			efp_pkg::OPND_X:     return {x_q[31], x_q};
			efp_pkg::OPND_Y:     return {y_q[31], y_q};
			efp_pkg::OPND_XX:    return {xx_q[31], xx_q};
			efp_pkg::OPND_YY:    return {yy_q[31], yy_q};
			efp_pkg::OPND_XY:    return {xy_q[31], xy_q};
			efp_pkg::OPND_CRE:   return {cfg.c_re[31], cfg.c_re};
			efp_pkg::OPND_CIM:   return {cfg.c_im[31], cfg.c_im};
			default:             return 33'sd0;
		endcase
	endfunction

	always_comb begin
		mul_a = opnd(ctl.opa);
		mul_b = opnd(ctl.opb);
	end

	assign prod  = mul_a * mul_b;

	// product scaled back to q8.24, floor rounding
	assign term = sat32(p_s1 >>> Q_FRAC);

	always_comb begin
		if (aop_s1 == efp_pkg::AOP_ADD2 || aop_s1 == efp_pkg::AOP_SUB2)
			term_sel = sat32(sx(term) + sx(term));
		else
			term_sel = term;
		acc_base = (dst_s1 == efp_pkg::DST_ACCY) ? accy_q : accx_q;
		case (aop_s1)
			efp_pkg::AOP_LD:   acc_res = term_sel;
			efp_pkg::AOP_ADD,
			efp_pkg::AOP_ADD2: acc_res = sat32(sx(acc_base) + sx(term_sel));
			default:           acc_res = sat32(sx(acc_base) - sx(term_sel));
		endcase
	end

	// quadratic map update, kind three falls back to mandelbrot
	always_comb begin
		cr     = (cfg.kind == efp_pkg::KIND_JULIA) ? cfg.c_re : x0_q;
		ci     = (cfg.kind == efp_pkg::KIND_JULIA) ? cfg.c_im : y0_q;
		quad_x = sat32(sx(sat32(sx(xx_q) - sx(yy_q))) + sx(cr));
		quad_y = sat32(sx(sat32(sx(xy_q) + sx(xy_q))) + sx(ci));
	end

	// exact squared magnitude, both squares non-negative
	assign mag   = sqx_q + $unsigned(p_s1);
	assign limit = (cfg.kind == efp_pkg::KIND_LAMBDA) ? LIM_LAMBDA : LIM_QUAD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dst_s1 <= efp_pkg::DST_NONE;
		else
			dst_s1 <= ctl.dst;
	end

	always_ff @(posedge clk) begin
		p_s1   <= prod[63:0];
		aop_s1 <= ctl.aop;
		if (ctl.ld) begin
			col_q <= col;
			row_q <= row;
		end
		case (dst_s1)
			efp_pkg::DST_NONE: ;
			efp_pkg::DST_X0: begin
				x0_q <= sat32(sx(cfg.x_start) + p_s1);
				x_q  <= sat32(sx(cfg.x_start) + p_s1);
			end
			efp_pkg::DST_Y0: begin
				y0_q <= sat32(sx(cfg.y_start) - p_s1);
				y_q  <= sat32(sx(cfg.y_start) - p_s1);
			end
			efp_pkg::DST_XX: begin
				xx_q  <= term;
				sqx_q <= $unsigned(p_s1);
			end
			efp_pkg::DST_YY: begin
				yy_q  <= term;
				esc_q <= (mag >= limit);
			end
			efp_pkg::DST_XY:   xy_q   <= term;
			efp_pkg::DST_ACCX: accx_q <= acc_res;
			efp_pkg::DST_ACCY: accy_q <= acc_res;
		endcase
		if (ctl.upd_quad) begin
			x_q <= quad_x;
			y_q <= quad_y;
		end
		if (ctl.upd_lam) begin
			x_q <= accx_q;
			y_q <= accy_q;
		end
	end

	assign sts.esc = esc_q;

endmodule

/* design/efp_seq.sv */
// sequencer: step program for the shared multiplier, step count and result word
module efp_seq #(
	parameter int MAX_ITER = 155
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    kind,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [23:0]   pixel_color,
	output logic [7:0]    step_count,
	output logic          escaped,
	output efp_pkg::ctl_t ctl,
	input  efp_pkg::sts_t sts
);

	localparam logic [7:0] CNT_LAST = 8'(MAX_ITER + 1);
	localparam logic [3:0] MAP_LAST = 4'd1;
	localparam logic [3:0] SQ_LAST  = 4'd3;
	localparam logic [3:0] LAM_LAST = 4'd11;

	efp_pkg::state_t state_q, state_d;
	logic [3:0]      step_q, step_d;
	logic [7:0]      cnt_q;
	logic            out_valid_q;
	logic [23:0]     pixel_color_q;
	logic [7:0]      step_count_q;
	logic            escaped_q;

	logic lambda, done, free, load_out, cnt_inc;

	assign lambda = (kind == efp_pkg::KIND_LAMBDA);
	// the magnitude of the start point is never tested
	assign done   = (cnt_q != 8'd0) && (sts.esc || cnt_q == CNT_LAST);
	assign free   = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		unique case (state_q)
			efp_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = efp_pkg::S_MAP;
					step_d  = 4'd0;
				end
			end
			efp_pkg::S_MAP: begin
				if (step_q == MAP_LAST) begin
					state_d = efp_pkg::S_SQ;
					step_d  = 4'd0;
				end else
					step_d = step_q + 4'd1;
			end
			efp_pkg::S_SQ: begin
				if (step_q == SQ_LAST) begin
					step_d = 4'd0;
					if (done)
						state_d = free ? efp_pkg::S_IDLE : efp_pkg::S_HOLD;
					else
						state_d = lambda ? efp_pkg::S_LAM : efp_pkg::S_CALC;
				end else
					step_d = step_q + 4'd1;
			end
			efp_pkg::S_CALC: begin
				state_d = efp_pkg::S_SQ;
				step_d  = 4'd0;
			end
			efp_pkg::S_LAM: begin
				if (step_q == LAM_LAST) begin
					state_d = efp_pkg::S_SQ;
					step_d  = 4'd0;
				end else
					step_d = step_q + 4'd1;
			end
			efp_pkg::S_HOLD: begin
				if (free)
					state_d = efp_pkg::S_IDLE;
			end
			default: state_d = efp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == efp_pkg::S_IDLE);
		ctl.ld       = in_valid && (state_q == efp_pkg::S_IDLE);
		ctl.opa      = efp_pkg::OPND_X;
		ctl.opb      = efp_pkg::OPND_X;
		ctl.dst      = efp_pkg::DST_NONE;
		ctl.aop      = efp_pkg::AOP_LD;
		ctl.upd_quad = 1'b0;
		ctl.upd_lam  = 1'b0;
		load_out     = 1'b0;
		cnt_inc      = 1'b0;
		unique case (state_q)
			efp_pkg::S_IDLE: ;
			efp_pkg::S_MAP: begin
				// start point: offsets col*x_step and row*y_step
				if (step_q == 4'd0) begin
					ctl.opa = efp_pkg::OPND_COL;
					ctl.opb = efp_pkg::OPND_XSTEP;
					ctl.dst = efp_pkg::DST_X0;
				end else begin
					ctl.opa = efp_pkg::OPND_ROW;
					ctl.opb = efp_pkg::OPND_YSTEP;
					ctl.dst = efp_pkg::DST_Y0;
				end
			end
			efp_pkg::S_SQ: begin
				case (step_q)
					4'd0: begin
						ctl.opa = efp_pkg::OPND_X;
						ctl.opb = efp_pkg::OPND_X;
						ctl.dst = efp_pkg::DST_XX;
					end
					4'd1: begin
						ctl.opa = efp_pkg::OPND_Y;
						ctl.opb = efp_pkg::OPND_Y;
						ctl.dst = efp_pkg::DST_YY;
					end
					4'd2: begin
						ctl.opa = efp_pkg::OPND_X;
						ctl.opb = efp_pkg::OPND_Y;
						ctl.dst = efp_pkg::DST_XY;
					end
					default: load_out = done && free;
				endcase
			end
			efp_pkg::S_CALC: begin
				ctl.upd_quad = 1'b1;
				cnt_inc      = 1'b1;
			end
			efp_pkg::S_LAM: begin
				// c*z*(1-z): real part into accx, imaginary part into accy
				case (step_q)
					4'd0: begin
						ctl.opa = efp_pkg::OPND_CRE; ctl.opb = efp_pkg::OPND_X;
						ctl.dst = efp_pkg::DST_ACCX; ctl.aop = efp_pkg::AOP_LD;
					end
					4'd1: begin
						ctl.opa = efp_pkg::OPND_CRE; ctl.opb = efp_pkg::OPND_XX;
						ctl.dst = efp_pkg::DST_ACCX; ctl.aop = efp_pkg::AOP_SUB;
					end
					4'd2: begin
						ctl.opa = efp_pkg::OPND_CRE; ctl.opb = efp_pkg::OPND_YY;
						ctl.dst = efp_pkg::DST_ACCX; ctl.aop = efp_pkg::AOP_ADD;
					end
					4'd3: begin
						ctl.opa = efp_pkg::OPND_CIM; ctl.opb = efp_pkg::OPND_Y;
						ctl.dst = efp_pkg::DST_ACCX; ctl.aop = efp_pkg::AOP_SUB;
					end
					4'd4: begin
						ctl.opa = efp_pkg::OPND_CIM; ctl.opb = efp_pkg::OPND_XY;
						ctl.dst = efp_pkg::DST_ACCX; ctl.aop = efp_pkg::AOP_ADD2;
					end
					4'd5: begin
						ctl.opa = efp_pkg::OPND_CRE; ctl.opb = efp_pkg::OPND_Y;
						ctl.dst = efp_pkg::DST_ACCY; ctl.aop = efp_pkg::AOP_LD;
					end
					4'd6: begin
						ctl.opa = efp_pkg::OPND_CIM; ctl.opb = efp_pkg::OPND_X;
						ctl.dst = efp_pkg::DST_ACCY; ctl.aop = efp_pkg::AOP_ADD;
					end
					4'd7: begin
						ctl.opa = efp_pkg::OPND_CIM; ctl.opb = efp_pkg::OPND_XX;
						ctl.dst = efp_pkg::DST_ACCY; ctl.aop = efp_pkg::AOP_SUB;
					end
					4'd8: begin
						ctl.opa = efp_pkg::OPND_CIM; ctl.opb = efp_pkg::OPND_YY;
						ctl.dst = efp_pkg::DST_ACCY; ctl.aop = efp_pkg::AOP_ADD;
					end
					4'd9: begin
						ctl.opa = efp_pkg::OPND_CRE; ctl.opb = efp_pkg::OPND_XY;
						ctl.dst = efp_pkg::DST_ACCY; ctl.aop = efp_pkg::AOP_SUB2;
					end
					4'd11: begin
						ctl.upd_lam = 1'b1;
						cnt_inc     = 1'b1;
					end
					default: ;
				endcase
			end
			efp_pkg::S_HOLD: load_out = free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= efp_pkg::S_IDLE;
			step_q      <= 4'd0;
			cnt_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (ctl.ld)
				cnt_q <= 8'd0;
			else if (cnt_inc)
				cnt_q <= cnt_q + 8'd1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixel_color_q <= sts.esc ? {cnt_q, cnt_q, cnt_q} : 24'd0;
			step_count_q  <= cnt_q;
			escaped_q     <= sts.esc;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_color = pixel_color_q;
	assign step_count  = step_count_q;
	assign escaped     = escaped_q;

endmodule

/* bench/escape_time_fractal_pixel_top_test.sv */
// self-checking bench for the escape-time fractal pixel engine
`timescale 1ns / 1ps
module escape_time_fractal_pixel_top_test;

	localparam int MAX_STEPS = 155;
	localparam longint CYCLE_LIMIT = 64'd20_000_000;
	localparam logic [1:0] KIND_MANDEL = 2'd0;
	localparam logic [1:0] KIND_ALIAS  = 2'd3;	// spare code, runs as mandelbrot

	// register defaults, Q8.24
	localparam int DEF_X_START = -41943040;
	localparam int DEF_Y_START = 25165824;
	localparam int DEF_X_STEP  = 65536;
	localparam int DEF_Y_STEP  = 49152;
	localparam int DEF_C_RE    = 5033165;
	localparam int DEF_C_IM    = 10066330;

	typedef struct packed {
		logic [23:0] color;
		logic [7:0]  steps;
		logic        esc;
	} pixel_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [efp_pkg::CFG_AW-1:0] paddr = '0;
	logic [31:0]                pwdata = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [9:0]                 col = '0;
	logic [9:0]                 row = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [23:0]                pixel_color;
	logic [7:0]                 step_count;
	logic                       escaped;

	efp_pkg::cfg_t view_cfg;
	pixel_t   pending_pixels[$];
	pixel_t   want;
	pixel_t   got;
	longint   cycle_count = 0;
	int       fail_count = 0;
	int       checked_count = 0;
	int       escaped_count = 0;
	int       view_count = 1;
	int       sink_hold = 0;
	bit       idle_on = 1'b1;

	escape_time_fractal_pixel_top #(.MAX_ITER(MAX_STEPS)) DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// exact product, floor shift back to Q8.24, then clamp
	function automatic longint fx_mul(input longint a, input longint b);
		return sat32((a * b) >>> 24);
	endfunction

	function automatic pixel_t escape_pixel(input logic [9:0] px_col, input logic [9:0] px_row);
		longint x0, y0, x, y, cre, cim, xx, yy, xy, nx, ny;
		longint unsigned mag, lim;
		int steps;
		bit lam;
		pixel_t res;
		lam = (view_cfg.kind == efp_pkg::KIND_LAMBDA);
		x0 = sat32(longint'($signed(view_cfg.x_start))
			+ longint'(px_col) * longint'(view_cfg.x_step));
		y0 = sat32(longint'($signed(view_cfg.y_start))
			- longint'(px_row) * longint'(view_cfg.y_step));
		cre = longint'($signed(view_cfg.c_re));
		cim = longint'($signed(view_cfg.c_im));
		lim = lam ? (64'd16 << 48) : (64'd4 << 48);
		x = x0;
		y = y0;
		mag = 0;
		steps = 0;
		while (steps <= MAX_STEPS && mag < lim) begin
			xx = fx_mul(x, x);
			yy = fx_mul(y, y);
			xy = fx_mul(x, y);
			if (lam) begin
				// c*z*(1-z) expanded term by term, each sum clamped
				nx = fx_mul(cre, x);
				nx = sat32(nx - fx_mul(cre, xx));
				nx = sat32(nx + fx_mul(cre, yy));
				nx = sat32(nx - fx_mul(cim, y));
				nx = sat32(nx + sat32(fx_mul(cim, xy) + fx_mul(cim, xy)));
				ny = fx_mul(cre, y);
				ny = sat32(ny + fx_mul(cim, x));
				ny = sat32(ny - fx_mul(cim, xx));
				ny = sat32(ny + fx_mul(cim, yy));
				ny = sat32(ny - sat32(fx_mul(cre, xy) + fx_mul(cre, xy)));
			end else if (view_cfg.kind == efp_pkg::KIND_JULIA) begin
				nx = sat32(sat32(xx - yy) + cre);
				ny = sat32(sat32(xy + xy) + cim);
			end else begin
				nx = sat32(sat32(xx - yy) + x0);
				ny = sat32(sat32(xy + xy) + y0);
			end
			x = nx;
			y = ny;
			mag = x * x + y * y;
			steps++;
		end
		res.esc = (mag >= lim);
		res.steps = 8'(steps);
		res.color = res.esc ? {3{8'(steps)}} : 24'd0;
		return res;
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			got = '{color: pixel_color, steps: step_count, esc: escaped};
			checked_count++;
			if (escaped)
				escaped_count++;
			if (pending_pixels.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected, got color=%h steps=%0d esc=%0b",
					$time, got.color, got.steps, got.esc);
			end else begin
				want = pending_pixels.pop_front();
				if (got.color !== want.color || got.steps !== want.steps
						|| got.esc !== want.esc) begin
					fail_count++;
					$display("%0t: expected color=%h steps=%0d esc=%0b, got color=%h steps=%0d esc=%0b",
						$time, want.color, want.steps, want.esc, got.color, got.steps, got.esc);
				end
			end
		end
	end

	// result sink: random stall per word, or a long hold when a test asks for one
	initial begin : result_sink
		int wait_cycles;
		forever begin
			if (sink_hold > 0) begin
				wait_cycles = sink_hold;
				sink_hold = 0;
			end else begin
				wait_cycles = idle_on ? $urandom_range(0, 6) : 0;
			end
			repeat (wait_cycles) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send_pixel(input logic [9:0] px_col, input logic [9:0] px_row);
		int gap;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		col <= px_col;
		row <= px_row;
		do @(posedge clk); while (!in_ready);
		pending_pixels.push_back(escape_pixel(px_col, px_row));
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input efp_pkg::reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			efp_pkg::REG_KIND:    view_cfg.kind = value[1:0];
			efp_pkg::REG_X_START: view_cfg.x_start = value;
			efp_pkg::REG_Y_START: view_cfg.y_start = value;
			efp_pkg::REG_X_STEP:  view_cfg.x_step = value[30:0];
			efp_pkg::REG_Y_STEP:  view_cfg.y_step = value[30:0];
			efp_pkg::REG_C_RE:    view_cfg.c_re = value;
			efp_pkg::REG_C_IM:    view_cfg.c_im = value;
			default: ;
		endcase
	endtask

	task automatic set_view(input logic [1:0] kind, input logic [31:0] xs, input logic [31:0] ys,
			input logic [31:0] xst, input logic [31:0] yst,
			input logic [31:0] cre, input logic [31:0] cim);
		drain_results();
		write_reg(efp_pkg::REG_KIND, {30'd0, kind});
		write_reg(efp_pkg::REG_X_START, xs);
		write_reg(efp_pkg::REG_Y_START, ys);
		write_reg(efp_pkg::REG_X_STEP, xst);
		write_reg(efp_pkg::REG_Y_STEP, yst);
		write_reg(efp_pkg::REG_C_RE, cre);
		write_reg(efp_pkg::REG_C_IM, cim);
		view_count++;
	endtask

	task automatic set_default_view(input logic [1:0] kind);
		set_view(kind, DEF_X_START, DEF_Y_START, DEF_X_STEP, DEF_Y_STEP, DEF_C_RE, DEF_C_IM);
	endtask

	task automatic test_directed_views();
		// reset defaults: image corners, the origin (never escapes), bit patterns
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd640, 10'd512);
		send_pixel(10'h155, 10'h2AA);
		send_pixel(10'h2AA, 10'h155);
		set_default_view(efp_pkg::KIND_JULIA);
		send_pixel(10'd512, 10'd512);
		send_pixel(10'd0, 10'd0);
		set_default_view(efp_pkg::KIND_LAMBDA);
		send_pixel(10'd640, 10'd512);
		send_pixel(10'd0, 10'd0);
		set_default_view(KIND_ALIAS);
		send_pixel(10'd640, 10'd512);
		send_pixel(10'd100, 10'd900);
		// start point clamps at both ends, top step bit dropped
		set_view(KIND_MANDEL, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'h80000000, 32'h7FFFFFFF);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		set_view(efp_pkg::KIND_LAMBDA, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'h80000000, 32'h7FFFFFFF);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		set_view(efp_pkg::KIND_JULIA, 32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd0,
			32'h7FFFFFFF, 32'h80000000);
		send_pixel(10'd5, 10'd5);
		// zero start point stays put
		set_view(KIND_MANDEL, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_pixel(10'd0, 10'd0);
		set_view(efp_pkg::KIND_LAMBDA, 32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFFFFFF, 32'd0);
		send_pixel(10'd1023, 10'd0);
	endtask

	task automatic test_mandelbrot_plane();
		set_default_view(KIND_MANDEL);
		send_random(550);
		// narrow window on the set boundary, long escape counts
		set_view(KIND_MANDEL, -13421773, 2516582, 1638, 1638, DEF_C_RE, DEF_C_IM);
		send_random(200);
	endtask

	task automatic test_julia_constants();
		set_view(efp_pkg::KIND_JULIA, -26843546, 20132659, 52429, 39322, DEF_C_RE, DEF_C_IM);
		send_random(100);
		set_view(efp_pkg::KIND_JULIA, -26843546, 20132659, 52429, 39322, -13421773, 2617245);
		send_random(100);
		set_view(efp_pkg::KIND_JULIA, -26843546, 20132659, 52429, 39322, 4781506, 167772);
		send_random(100);
		set_view(efp_pkg::KIND_JULIA, -26843546, 20132659, 52429, 39322, -6710886, 10066330);
		send_random(100);
	endtask

	task automatic test_lambda_map();
		set_view(efp_pkg::KIND_LAMBDA, -16777216, DEF_Y_START, 49152, 49152, 48653517, 0);
		send_random(70);
		set_view(efp_pkg::KIND_LAMBDA, -16777216, DEF_Y_START, 49152, 49152, 53687091, 5033165);
		send_random(70);
	endtask

	task automatic test_unused_kind();
		set_default_view(KIND_ALIAS);
		send_random(100);
	endtask

	task automatic test_back_to_back();
		set_default_view(KIND_MANDEL);
		idle_on = 1'b0;
		send_random(150);
		drain_results();
		idle_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		set_default_view(KIND_MANDEL);
		// sink holds off while words keep coming, so the input must stall
		idle_on = 1'b0;
		sink_hold = 1500;
		send_random(10);
		drain_results();
		sink_hold = 600;
		send_random(10);
		drain_results();
		idle_on = 1'b1;
	endtask

	task automatic test_random_registers();
		logic [31:0] xs, ys, xst, yst, cre, cim;
		for (int phase = 0; phase < 10; phase++) begin
			if (phase % 2 == 0) begin
				// whole range, start points mostly clamp
				xs = $urandom;
				ys = $urandom;
				xst = $urandom;
				yst = $urandom;
				cre = $urandom;
				cim = $urandom;
			end else begin
				// within about 3 of the origin, fine steps, constant within 2
				xs = int'($urandom_range(0, 100663296)) - 50331648;
				ys = int'($urandom_range(0, 100663296)) - 50331648;
				xst = $urandom_range(0, 131072);
				yst = $urandom_range(0, 131072);
				cre = int'($urandom_range(0, 67108864)) - 33554432;
				cim = int'($urandom_range(0, 67108864)) - 33554432;
			end
			set_view(2'($urandom_range(0, 3)), xs, ys, xst, yst, cre, cim);
			send_random(30);
		end
	endtask

	initial begin
		view_cfg.kind = KIND_MANDEL;
		view_cfg.x_start = DEF_X_START;
		view_cfg.y_start = DEF_Y_START;
		view_cfg.x_step = DEF_X_STEP;
		view_cfg.y_step = DEF_Y_STEP;
		view_cfg.c_re = DEF_C_RE;
		view_cfg.c_im = DEF_C_IM;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_views();
		test_mandelbrot_plane();
		test_julia_constants();
		test_lambda_map();
		test_unused_kind();
		test_back_to_back();
		test_output_backpressure();
		test_random_registers();
		drain_results();
		repeat (2600) @(posedge clk);
		$display("checked %0d pixels over %0d register settings in %0d cycles",
			checked_count, view_count, cycle_count);
		$display("%0d escaped, %0d stayed bounded, %0d mismatches",
			escaped_count, checked_count - escaped_count, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
design/efp_pkg.sv
design/efp_regs.sv
design/efp_dp.sv
design/efp_seq.sv
design/escape_time_fractal_pixel_top.sv
bench/escape_time_fractal_pixel_top_test.sv
